/* src/x86_operand_prefix_modrm_encoder_defines.svh */
// assertion macros for the encoder's back end module
// depends on clk and rst_n being visible at the point of use
`ifndef X86_OPERAND_PREFIX_MODRM_ENCODER_DEFINES_SVH
`define X86_OPERAND_PREFIX_MODRM_ENCODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define XOPME_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define XOPME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/xopme_pkg.sv */
// types and constants of the x86 operand prefix / ModR/M encoder
// no dependencies
package xopme_pkg;

  localparam int NSLOT = 8;

  // operand size codes
  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_64 = 2'd3;

  // prefix and rex encoding
  localparam logic [7:0] PFX_OPSIZE = 8'h66;
  localparam logic [7:0] REX_BASE   = 8'h40;
  localparam logic [7:0] REX_W      = 8'h08;
  localparam logic [7:0] REX_R      = 8'h04;
  localparam logic [7:0] REX_B      = 8'h01;

  // modrm mod field values
  localparam logic [1:0] MOD_IND    = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP32 = 2'b10;
  localparam logic [1:0] MOD_REG    = 2'b11;

  // special base registers in memory form
  localparam logic [3:0] BASE_SP = 4'd4;
  localparam logic [2:0] BASE_BP = 3'd5;

  // disp8 range
  localparam logic signed [31:0] DISP8_MIN = -32'sd128;
  localparam logic signed [31:0] DISP8_MAX = 32'sd127;

  // byte slots in emission order
  localparam logic [2:0] SLOT_PFX   = 3'd0;
  localparam logic [2:0] SLOT_REX   = 3'd1;
  localparam logic [2:0] SLOT_OPC   = 3'd2;
  localparam logic [2:0] SLOT_MODRM = 3'd3;
  localparam logic [2:0] SLOT_DISP0 = 3'd4;
  localparam logic [2:0] SLOT_DISP1 = 3'd5;
  localparam logic [2:0] SLOT_DISP2 = 3'd6;
  localparam logic [2:0] SLOT_DISP3 = 3'd7;

  // one classified instruction waiting for the back end
  typedef struct packed {
    logic             err;
    logic [NSLOT-1:0] mask;
    logic [7:0]       rex;
    logic [7:0]       opc;
    logic [7:0]       modrm;
    logic [31:0]      disp;
  } xopme_job_t;

  // byte carried by one slot of a job
  function automatic logic [7:0] slot_byte(xopme_job_t job, logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      SLOT_PFX:   b = PFX_OPSIZE;
      SLOT_REX:   b = job.rex;
      SLOT_OPC:   b = job.opc;
      SLOT_MODRM: b = job.modrm;
      SLOT_DISP0: b = job.disp[7:0];
      SLOT_DISP1: b = job.disp[15:8];
      SLOT_DISP2: b = job.disp[23:16];
      SLOT_DISP3: b = job.disp[31:24];
      default:    b = '0;
    endcase
    if (job.err) begin
      b = '0;
    end
    return b;
  endfunction

endpackage

/* src/xopme_if.sv */
// valid/ready channel interfaces for descriptors and encoded bytes
// no dependencies
interface xopme_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [7:0]         opcode;
  logic [1:0]         size_code;
  logic [3:0]         reg_index;
  logic [3:0]         base_index;
  logic signed [31:0] displacement;

  modport source (output valid, func, opcode, size_code, reg_index, base_index,
                  displacement, input ready);
  modport sink (input valid, func, opcode, size_code, reg_index, base_index,
                displacement, output ready);
endinterface

interface xopme_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink (input valid, out_byte, last, error, output ready);
endinterface

/* src/xopme_front.sv */
// front end: accepts a descriptor and classifies it into a slot job
// depends on xopme_pkg and xopme_in_if
module xopme_front
  import xopme_pkg::*;
(
  xopme_in_if.sink   in_ch,
  input  logic       q_full,
  output logic       push,
  output xopme_job_t push_job
);

  logic       mem;
  logic [3:0] rexbase;
  logic       reg_hi;
  logic       base_hi;
  logic       bad;
  logic       has66;
  logic       has_rex;
  logic [7:0] rex_bits;
  logic       disp_zero;
  logic       disp_short;
  logic [1:0] modf;
  logic       disp1;
  logic       disp4;

  // accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // classification
  always_comb begin
    mem      = in_ch.func;
    rexbase  = mem ? 4'd0 : in_ch.base_index;
    reg_hi   = in_ch.reg_index[3];
    base_hi  = rexbase[3];
    bad      = !in_ch.opcode[0] ||
               (mem && (in_ch.base_index[3] || in_ch.base_index == BASE_SP));
    rex_bits = (reg_hi ? REX_R : 8'h00) | (base_hi ? REX_B : 8'h00);
    has66    = 1'b0;
    if (in_ch.size_code == SIZE_8) begin
      has_rex = (in_ch.reg_index > 4'd3) || (rexbase > 4'd3);
    end else begin
      if (in_ch.size_code == SIZE_64) begin
        rex_bits = rex_bits | REX_W;
      end
      has_rex = (rex_bits != 8'h00);
      has66   = (in_ch.size_code == SIZE_16);
    end

    // modrm mode and displacement length
    disp_zero  = (in_ch.displacement == 32'sd0) && (in_ch.base_index[2:0] != BASE_BP);
    disp_short = (in_ch.displacement >= DISP8_MIN) && (in_ch.displacement <= DISP8_MAX);
    disp1      = 1'b0;
    disp4      = 1'b0;
    if (!mem) begin
      modf = MOD_REG;
    end else if (disp_zero) begin
      modf = MOD_IND;
    end else if (disp_short) begin
      modf  = MOD_DISP8;
      disp1 = 1'b1;
    end else begin
      modf  = MOD_DISP32;
      disp1 = 1'b1;
      disp4 = 1'b1;
    end

    push_job.err   = bad;
    push_job.rex   = REX_BASE | rex_bits;
    push_job.opc   = (in_ch.size_code == SIZE_8) ? (in_ch.opcode ^ 8'h01) : in_ch.opcode;
    push_job.modrm = {modf, in_ch.reg_index[2:0], in_ch.base_index[2:0]};
    push_job.disp  = in_ch.displacement;
    if (bad) begin
      push_job.mask = {{(NSLOT-1){1'b0}}, 1'b1};
    end else begin
      push_job.mask = {disp4, disp4, disp4, disp1, 1'b1, 1'b1, has_rex, has66};
    end
  end

endmodule

/* src/xopme_queue.sv */
// small fifo of classified jobs between front and back end
// depends on xopme_pkg
module xopme_queue
  import xopme_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  xopme_job_t push_job,
  output logic       full,
  input  logic       pop,
  output logic       valid,
  output xopme_job_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  xopme_job_t    jobs_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign valid = (count_r != '0);
  assign head  = jobs_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      jobs_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* src/xopme_back.sv */
// back end: walks the slots of the head job and sends one byte per transaction
// depends on xopme_pkg, xopme_out_if and the assertion macro header
`include "x86_operand_prefix_modrm_encoder_defines.svh"

module xopme_back
  import xopme_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  xopme_job_t  head,
  output logic        pop,
  xopme_out_if.source out_ch
);

  logic             started_r, started_nxt;
  logic [NSLOT-1:0] rem_r, rem_nxt;
  logic             ov_r;
  logic [7:0]       ob_r;
  logic             ol_r;
  logic             oe_r;
  logic             load;
  logic [NSLOT-1:0] mask_now;
  logic [NSLOT-1:0] low;
  logic [NSLOT-1:0] left;
  logic [7:0]       byte_sel;

  assign out_ch.valid    = ov_r;
  assign out_ch.out_byte = ob_r;
  assign out_ch.last     = ol_r;
  assign out_ch.error    = oe_r;

  // pick the next pending slot of the head job
  always_comb begin
    load     = q_valid && (!ov_r || out_ch.ready);
    mask_now = started_r ? rem_r : head.mask;
    low      = mask_now & (~mask_now + 1'b1);
    left     = mask_now & ~low;
    byte_sel = '0;
    for (int i = 0; i < NSLOT; i++) begin
      if (low[i]) begin
        byte_sel = byte_sel | slot_byte(head, 3'(i));
      end
    end
    pop         = load && (left == '0);
    started_nxt = started_r;
    rem_nxt     = rem_r;
    if (load) begin
      started_nxt = (left != '0);
      rem_nxt     = left;
    end
  end

  // slot walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
    end else begin
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob_r <= byte_sel;
      ol_r <= (left == '0);
      oe_r <= head.err;
    end
  end

  `XOPME_ASSERT_NOW(a_err_is_last, ov_r && oe_r, ol_r && (ob_r == 8'h00), "error transaction must be a lone zero byte")
  `XOPME_ASSERT_NOW(a_walk_has_job, started_r, q_valid && (rem_r != '0), "slot walk in progress without a queued job")
  `XOPME_ASSERT_NEXT(a_load_shows, load, ov_r, "loaded byte not presented on the output")

endmodule

/* src/x86_operand_prefix_modrm_encoder.sv */
// Encodes x86-64 instruction descriptors (register-direct or base plus
// displacement) into 0x66 prefix, REX, opcode, ModR/M and displacement bytes,
// one byte per output transaction with last on the final byte; an illegal
// descriptor gives one zero byte with error and last set. A descriptor is
// accepted whenever the job queue has room, so new descriptors come in while
// earlier ones are still being sent. The byte sequencer sends one byte per
// cycle while the output is ready, with no gap between queued instructions;
// an instruction is 1 to 8 bytes (typically 3 to 4), and the sustained rate
// is set by the single-byte output register.
// depends on xopme_pkg, xopme_if, xopme_front, xopme_queue, xopme_back
module x86_operand_prefix_modrm_encoder
  import xopme_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  xopme_in_if.sink    in_ch,
  xopme_out_if.source out_ch
);

  logic       push;
  logic       q_full;
  logic       q_valid;
  logic       pop;
  xopme_job_t push_job;
  xopme_job_t head;

  // descriptor classification
  xopme_front u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // decoupling queue
  xopme_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (head)
  );

  // byte sequencer
  xopme_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
